FILE: rtl/core/otg_pkg.sv
// Shared types and constants for the OLED text glyph renderer.
// Used by otg_ctrl, otg_datapath and oled_text_glyph_renderer; no dependencies.
`timescale 1ns / 1ps
`default_nettype none

package otg_pkg;

  // Character codes with a special meaning.
  localparam logic [7:0] CHAR_BAR  = 8'h7C;
  localparam logic [7:0] CHAR_ONE  = 8'h31;
  localparam logic [7:0] CHAR_TWO  = 8'h32;
  localparam logic [7:0] CHAR_FOUR = 8'h34;

  // Glyph geometry: five columns, font starts at the space character.
  localparam logic [2:0] GLYPH_LAST_COL = 3'd4;
  localparam logic [9:0] GLYPH_BASE     = 10'd160;

  // Scale codes; the unused code draws at 1x.
  localparam logic [1:0] SCALE_1X = 2'd0;
  localparam logic [1:0] SCALE_2X = 2'd1;
  localparam logic [1:0] SCALE_4X = 2'd2;

  typedef struct packed {
    logic       mode;
    logic       start_string;
    logic [7:0] char_code;
    logic [9:0] font_index;
    logic [7:0] font_byte;
  } otg_in_t;

  typedef struct packed {
    logic [9:0] fb_address;
    logic [7:0] fb_byte;
    logic       last;
  } otg_out_t;

  // Controller to datapath.
  typedef struct packed {
    logic       take;
    logic       newline;
    logic       set_scale;
    logic       fetch;
    logic [2:0] fetch_col;
    logic       write;
    logic [1:0] sub;
    logic       advance;
    logic       flush;
  } otg_cmd_t;

  // Datapath to controller.
  typedef struct packed {
    logic       in_mode;
    logic       is_bar;
    logic       is_digit;
    logic       at_start;
    logic [1:0] scale;
    logic       push_ok;
  } otg_stat_t;

  // Each glyph bit becomes a vertical pair of pixels.
  function automatic logic [7:0] spread_nibble(input logic [3:0] nib);
    logic [7:0] r;
    r = 8'h00;
    if (nib[3]) r = r | 8'hc0;
    if (nib[2]) r = r | 8'h30;
    if (nib[1]) r = r | 8'h0c;
    if (nib[0]) r = r | 8'h03;
    return r;
  endfunction

endpackage

`default_nettype wire

FILE: rtl/core/oled_text_glyph_renderer.sv
// Top level of the OLED text glyph renderer.
// Depends on otg_pkg, otg_ctrl and otg_datapath.
`timescale 1ns / 1ps
`default_nettype none

// Turns characters into byte writes for a page-organized framebuffer. A load
// request (mode 0) stores one font byte. A render request stalls the input
// from acceptance until it is done; '|' and scale digits finish in the decode
// step. A glyph gives one write per framebuffer byte; the single output
// register takes one write per cycle while the output is not stalled, with
// the font memory read of each column overlapped with the previous column's
// last write. A stalled output holds the writes back. Writes beyond the
// framebuffer are dropped but still take their place in the write sequence.
// The last flag marks the final surviving write of a character; a character
// with no surviving write gives no result.
module oled_text_glyph_renderer #(
  parameter int FB_BYTES   = 1024,
  parameter int LINE_BYTES = 128,
  parameter int FONT_BYTES = 1024
) (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             in_valid,
  output logic             in_stall,
  input  otg_pkg::otg_in_t in_data,
  output logic             out_valid,
  input  logic             out_stall,
  output otg_pkg::otg_out_t out_data
);
  import otg_pkg::*;

  otg_cmd_t  cmd;
  otg_stat_t stat;

  otg_ctrl u_ctrl (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_valid),
    .in_stall (in_stall),
    .stat     (stat),
    .cmd      (cmd)
  );

  otg_datapath #(
    .FB_BYTES   (FB_BYTES),
    .LINE_BYTES (LINE_BYTES),
    .FONT_BYTES (FONT_BYTES)
  ) u_datapath (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_data   (in_data),
    .cmd       (cmd),
    .stat      (stat),
    .out_stall (out_stall),
    .out_valid (out_valid),
    .out_data  (out_data)
  );

endmodule

`default_nettype wire

FILE: rtl/core/otg_ctrl.sv
// Sequencing state machine of the OLED text glyph renderer.
// Depends on otg_pkg; drives otg_datapath through command and status structs.
`timescale 1ns / 1ps
`default_nettype none

module otg_ctrl (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              in_valid,
  output logic              in_stall,
  input  otg_pkg::otg_stat_t stat,
  output otg_pkg::otg_cmd_t  cmd
);
  import otg_pkg::*;

  typedef enum logic [1:0] {S_IDLE, S_DECIDE, S_WRITE, S_GAP} state_t;

  state_t     state_r, state_nxt;
  logic [2:0] col_r, col_nxt;
  logic [1:0] sub_r, sub_nxt;
  logic [1:0] sub_max;

  always_comb begin
    unique case (stat.scale)
      SCALE_2X: sub_max = 2'd1;
      SCALE_4X: sub_max = 2'd3;
      default:  sub_max = 2'd0;
    endcase
  end

  assign in_stall = (state_r != S_IDLE);

  always_comb begin
    state_nxt = state_r;
    col_nxt   = col_r;
    sub_nxt   = sub_r;
    cmd       = '0;
    cmd.sub   = sub_r;
    unique case (state_r)
      S_IDLE: begin
        cmd.take = in_valid;
        if (in_valid && stat.in_mode) begin
          state_nxt = S_DECIDE;
        end
      end
      S_DECIDE: begin
        if (stat.is_bar) begin
          cmd.newline = 1'b1;
          state_nxt   = S_IDLE;
        end else if (stat.at_start && stat.is_digit) begin
          cmd.set_scale = 1'b1;
          cmd.advance   = 1'b1;
          state_nxt     = S_IDLE;
        end else begin
          cmd.fetch     = 1'b1;
          cmd.fetch_col = 3'd0;
          col_nxt       = 3'd0;
          sub_nxt       = 2'd0;
          state_nxt     = S_WRITE;
        end
      end
      S_WRITE: begin
        if (stat.push_ok) begin
          cmd.write   = 1'b1;
          // The first two writes of a column move the pointer; the 4x
          // lower-page writes reuse the same two columns.
          cmd.advance = ~sub_r[1];
          if (sub_r == sub_max) begin
            sub_nxt = 2'd0;
            if (col_r == GLYPH_LAST_COL) begin
              state_nxt = S_GAP;
            end else begin
              // The next column is read while this one's last byte goes out.
              col_nxt       = col_r + 3'd1;
              cmd.fetch     = 1'b1;
              cmd.fetch_col = col_r + 3'd1;
            end
          end else begin
            sub_nxt = sub_r + 2'd1;
          end
        end
      end
      S_GAP: begin
        if (stat.push_ok) begin
          cmd.advance = 1'b1;
          cmd.flush   = 1'b1;
          state_nxt   = S_IDLE;
        end
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
      col_r   <= 3'd0;
      sub_r   <= 2'd0;
    end else begin
      state_r <= state_nxt;
      col_r   <= col_nxt;
      sub_r   <= sub_nxt;
    end
  end

  a_col_bound: assert property (@(posedge clk) disable iff (!rst_n)
    state_r == S_WRITE |-> col_r <= GLYPH_LAST_COL)
    else $error("column counter ran past the glyph");

  a_fetch_leads_write: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.fetch |=> state_r == S_WRITE && sub_r == 2'd0)
    else $error("glyph read not followed by its first write");

endmodule

`default_nettype wire

FILE: rtl/core/otg_datapath.sv
// Datapath of the OLED text glyph renderer: font memory, pointer state,
// address generation and the hold and output registers. Depends on otg_pkg.
`timescale 1ns / 1ps
`default_nettype none

module otg_datapath #(
  parameter int FB_BYTES   = 1024,
  parameter int LINE_BYTES = 128,
  parameter int FONT_BYTES = 1024
) (
  input  logic               clk,
  input  logic               rst_n,
  input  otg_pkg::otg_in_t   in_data,
  input  otg_pkg::otg_cmd_t  cmd,
  output otg_pkg::otg_stat_t stat,
  input  logic               out_stall,
  output logic               out_valid,
  output otg_pkg::otg_out_t  out_data
);
  import otg_pkg::*;

  localparam int FI_W = $clog2(FONT_BYTES);
  localparam int LC_W = $clog2(LINE_BYTES);

  // Font indices are 10 bits; with a store of at least half their range, one
  // subtract folds them into the store.
  function automatic logic [FI_W-1:0] font_addr(input logic [9:0] idx);
    logic [12:0] t;
    t = {3'b000, idx};
    if (t >= 13'(FONT_BYTES)) t = t - 13'(FONT_BYTES);
    return FI_W'(t);
  endfunction

  logic [7:0] font_mem [FONT_BYTES];
  logic [7:0] glyph_r;

  logic [15:0]     wp_r, wp_nxt;
  logic [LC_W-1:0] col_r, col_nxt;
  logic [7:0]      line_r, line_nxt;
  logic [1:0]      scale_r, scale_nxt;
  logic [7:0]      ch_r;
  logic [15:0]     colp_r;

  logic            hold_valid_r, hold_valid_nxt;
  logic [9:0]      hold_addr_r, hold_addr_nxt;
  logic [7:0]      hold_byte_r, hold_byte_nxt;
  logic            out_valid_r, out_valid_nxt;
  otg_out_t        out_r, out_nxt;

  logic [9:0]  glyph_idx;
  logic [15:0] base, pos;
  logic [16:0] addr;
  logic        kept;
  logic [7:0]  wr_byte;
  logic        start_now;

  assign glyph_idx = 10'({2'b00, ch_r} * 10'd5 + {7'b0, cmd.fetch_col} - GLYPH_BASE);

  always_ff @(posedge clk) begin
    if (cmd.take && !in_data.mode) begin
      font_mem[font_addr(in_data.font_index)] <= in_data.font_byte;
    end
    if (cmd.fetch) begin
      glyph_r <= font_mem[font_addr(glyph_idx)];
    end
  end

  assign stat.in_mode  = in_data.mode;
  assign stat.is_bar   = (ch_r == CHAR_BAR);
  assign stat.is_digit = (ch_r == CHAR_ONE) || (ch_r == CHAR_TWO) || (ch_r == CHAR_FOUR);
  assign stat.at_start = (col_r == '0);
  assign stat.scale    = scale_r;
  assign stat.push_ok  = !out_valid_r || !out_stall;

  // Write address: first write of a column sits at the pointer, the rest are
  // relative to the column base latched then.
  always_comb begin
    base = (cmd.sub == 2'd0) ? wp_r : colp_r;
    pos  = cmd.sub[0] ? base + 16'd1 : base;
    addr = {1'b0, pos} + (cmd.sub[1] ? 17'(LINE_BYTES) : 17'd0);
    kept = (addr < 17'(FB_BYTES));
    if (scale_r == SCALE_4X) begin
      wr_byte = spread_nibble(cmd.sub[1] ? glyph_r[7:4] : glyph_r[3:0]);
    end else begin
      wr_byte = glyph_r;
    end
  end

  assign start_now = cmd.take && in_data.mode && in_data.start_string;

  always_comb begin
    wp_nxt    = wp_r;
    col_nxt   = col_r;
    line_nxt  = line_r;
    scale_nxt = scale_r;
    if (start_now) begin
      wp_nxt    = 16'd0;
      col_nxt   = '0;
      line_nxt  = 8'd0;
      scale_nxt = SCALE_1X;
    end
    if (cmd.newline) begin
      line_nxt = line_r + 8'd1;
      wp_nxt   = 16'(16'(LINE_BYTES) * {8'd0, line_nxt});
      col_nxt  = '0;
    end
    if (cmd.set_scale) begin
      if (ch_r == CHAR_ONE) begin
        scale_nxt = SCALE_1X;
      end else if (ch_r == CHAR_TWO) begin
        scale_nxt = SCALE_2X;
      end else begin
        scale_nxt = SCALE_4X;
      end
    end
    if (cmd.advance) begin
      // The column within the page is tracked alongside the pointer; a
      // pointer wrap lands on a page start.
      if (wp_r == 16'hFFFF) begin
        wp_nxt  = 16'd0;
        col_nxt = '0;
      end else begin
        wp_nxt  = wp_r + 16'd1;
        col_nxt = (col_r == LC_W'(LINE_BYTES - 1)) ? '0 : col_r + 1'b1;
      end
    end
  end

  // A kept write waits in the hold register until the next kept write or the
  // end of the character shows whether it is the last one.
  always_comb begin
    out_valid_nxt  = out_valid_r && out_stall;
    out_nxt        = out_r;
    hold_valid_nxt = hold_valid_r;
    hold_addr_nxt  = hold_addr_r;
    hold_byte_nxt  = hold_byte_r;
    if (cmd.write && kept) begin
      if (hold_valid_r) begin
        out_valid_nxt      = 1'b1;
        out_nxt.fb_address = hold_addr_r;
        out_nxt.fb_byte    = hold_byte_r;
        out_nxt.last       = 1'b0;
      end
      hold_valid_nxt = 1'b1;
      hold_addr_nxt  = addr[9:0];
      hold_byte_nxt  = wr_byte;
    end
    if (cmd.flush && hold_valid_r) begin
      out_valid_nxt      = 1'b1;
      out_nxt.fb_address = hold_addr_r;
      out_nxt.fb_byte    = hold_byte_r;
      out_nxt.last       = 1'b1;
      hold_valid_nxt     = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wp_r         <= 16'd0;
      col_r        <= '0;
      line_r       <= 8'd0;
      scale_r      <= SCALE_1X;
      hold_valid_r <= 1'b0;
      out_valid_r  <= 1'b0;
    end else begin
      wp_r         <= wp_nxt;
      col_r        <= col_nxt;
      line_r       <= line_nxt;
      scale_r      <= scale_nxt;
      hold_valid_r <= hold_valid_nxt;
      out_valid_r  <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.take) begin
      ch_r <= in_data.char_code;
    end
    if (cmd.write && cmd.sub == 2'd0) begin
      colp_r <= wp_r;
    end
    hold_addr_r <= hold_addr_nxt;
    hold_byte_r <= hold_byte_nxt;
    out_r       <= out_nxt;
  end

  assign out_valid = out_valid_r;
  assign out_data  = out_r;

  a_flush_marks_last: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.flush && hold_valid_r |=> out_valid_r && out_r.last && !hold_valid_r)
    else $error("flushed write did not leave with the last flag");

  a_push_not_last: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.write && kept && hold_valid_r |=> out_valid_r && !out_r.last && hold_valid_r)
    else $error("held write displaced without going out");

  a_push_when_free: assert property (@(posedge clk) disable iff (!rst_n)
    (cmd.write || cmd.flush) |-> !out_valid_r || !out_stall)
    else $error("write step issued while the output register is blocked");

endmodule

`default_nettype wire
